// ===== hw/rtl/hlbc_pkg.sv =====
package hlbc_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int NUM_BUCKETS = 13;
  localparam int NUM_LISTS   = 2 * NUM_BUCKETS + 1;
  localparam int IDX_W       = $clog2(NUM_BUFFERS);
  localparam int LINK_W      = IDX_W + 1;
  localparam int LIST_W      = $clog2(NUM_LISTS);
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int BLK_W       = 32;
  localparam int DEV_W       = 8;
  localparam int CNT_W       = 8;

  // Reciprocal of the bucket count, rounded up, so that the quotient taken
  // from the top product bits is exact for every block number.
  localparam int RECIP_SH = BLK_W + BKT_W;
  localparam logic [BLK_W:0] RECIP_M =
    (BLK_W+1)'(((64'd1 << RECIP_SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [LIST_W-1:0] list_t;
  typedef logic [BKT_W-1:0]  bkt_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [1:0]        kind_t;
  typedef logic [1:0]        stat_t;

  // A link with its top bit set points nowhere.
  localparam link_t LINK_NIL = {1'b1, {IDX_W{1'b0}}};
  localparam list_t FREE_ID  = list_t'(2 * NUM_BUCKETS);
  localparam cnt_t  CNT_MAX  = {CNT_W{1'b1}};

  localparam kind_t K_GET     = 2'd0;
  localparam kind_t K_RELEASE = 2'd1;
  localparam kind_t K_PIN     = 2'd2;
  localparam kind_t K_UNPIN   = 2'd3;

  localparam stat_t ST_OK     = 2'd0;
  localparam stat_t ST_NOBUF  = 2'd1;
  localparam stat_t ST_CNTERR = 2'd2;

endpackage

// ===== hw/rtl/hlbc_if.sv =====
interface hlbc_in_if import hlbc_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  logic [DEV_W-1:0] device;
  logic [BLK_W-1:0] block;
  idx_t  buffer_in;

  modport source(output valid, kind, device, block, buffer_in, input ready);
  modport sink(input valid, kind, device, block, buffer_in, output ready);
endinterface

interface hlbc_out_if import hlbc_pkg::*; ();
  logic  valid;
  logic  ready;
  idx_t  buffer_out;
  stat_t status;
  logic  tag_hit;
  logic  need_read;
  cnt_t  count_after;

  modport source(output valid, buffer_out, status, tag_hit, need_read, count_after,
                 input ready);
  modport sink(input valid, buffer_out, status, tag_hit, need_read, count_after,
               output ready);
endinterface

// ===== hw/rtl/hashed_lru_buffer_cache.sv =====
// Release, pin and unpin pass S_OP and S_FIN; a release that moves the buffer also
// passes S_UNL and S_PUSH. A get accepts and hashes the block in S_MODH and S_MODQ,
// then walks each list from S_START through S_WALK to the list end, checks for a victim,
// scans up to NUM_BUCKETS-1 other buckets' idle lists and relinks in S_UNL and S_PUSH.
// One item is in work at a time; the result register frees the input side.
// Synchronous active-low reset rebuilds all lists; tags stay unset.
module hashed_lru_buffer_cache import hlbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hlbc_in_if.sink     in_if,
  hlbc_out_if.source  out_if
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MODH  = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_VIC   = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_UNL   = 4'd6;
  localparam logic [3:0] S_PUSH  = 4'd7;
  localparam logic [3:0] S_OP    = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_MODQ  = 4'd10;

  logic [3:0] state_r;
  kind_t      kind_r;
  logic [DEV_W-1:0] dev_r;
  logic [BLK_W-1:0] blk_r;
  idx_t       bin_r;
  logic [2*BLK_W:0] prod_r;
  bkt_t       rem_r;
  bkt_t       bkt_r;
  bkt_t       k_r;
  logic       lst_idle_r;
  logic       victim_r;
  link_t      cur_r;
  list_t      tgt_r;

  idx_t       res_bo_r;
  stat_t      res_st_r;
  logic       res_hit_r;
  cnt_t       res_cnt_r;
  logic       grant_r;

  logic       out_valid_r;
  idx_t       out_bo_r;
  stat_t      out_st_r;
  logic       out_hit_r;
  logic       out_rd_r;
  cnt_t       out_cnt_r;

  cnt_t       ref_r  [NUM_BUFFERS];
  logic       vld_r  [NUM_BUFFERS];
  link_t      nxt_r  [NUM_BUFFERS];
  link_t      prv_r  [NUM_BUFFERS];
  list_t      own_r  [NUM_BUFFERS];
  link_t      head_r [NUM_LISTS];
  link_t      tail_r [NUM_LISTS];

  logic [DEV_W-1:0] tdev_mem_r [NUM_BUFFERS];
  logic [BLK_W-1:0] tblk_mem_r [NUM_BUFFERS];
  logic [DEV_W-1:0] tdev_q_r;
  logic [BLK_W-1:0] tblk_q_r;

  idx_t       cb;
  link_t      u_p;
  link_t      u_n;
  list_t      u_l;
  link_t      p_hd;
  list_t      start_l;
  list_t      home_idle;
  logic [BLK_W-1:0] quo;
  logic [BLK_W-1:0] quo_x;
  logic       tag_match;
  logic       tag_we;
  idx_t       tag_raddr;
  cnt_t       hcnt;
  list_t      hown;
  bkt_t       home_p1;
  bkt_t       bkt_p1;
  link_t      scan_t;
  link_t      vic_t;
  logic       fin_fire;

  assign cb        = cur_r[IDX_W-1:0];
  assign u_p       = prv_r[cb];
  assign u_n       = nxt_r[cb];
  assign u_l       = own_r[cb];
  assign p_hd      = head_r[tgt_r];
  assign home_idle = list_t'(rem_r) + list_t'(NUM_BUCKETS);
  assign start_l   = lst_idle_r ? home_idle : list_t'(rem_r);
  assign quo       = BLK_W'(prod_r >> RECIP_SH);
  assign quo_x     = quo * BLK_W'(NUM_BUCKETS);
  assign tag_match = !cur_r[IDX_W] && (tdev_q_r == dev_r) && (tblk_q_r == blk_r);
  assign hcnt      = ref_r[bin_r];
  assign hown      = own_r[bin_r];
  assign home_p1   = (rem_r == bkt_t'(NUM_BUCKETS - 1)) ? '0 : rem_r + bkt_t'(1);
  assign bkt_p1    = (bkt_r == bkt_t'(NUM_BUCKETS - 1)) ? '0 : bkt_r + bkt_t'(1);
  assign scan_t    = tail_r[list_t'(bkt_r) + list_t'(NUM_BUCKETS)];
  assign vic_t     = tail_r[home_idle];
  assign fin_fire  = (state_r == S_FIN) && (!out_valid_r || out_if.ready);
  assign tag_we    = (state_r == S_UNL) && (kind_r == K_GET) && victim_r;

  always_comb begin
    tag_raddr = cb;
    if (state_r == S_START) begin
      tag_raddr = head_r[start_l][IDX_W-1:0];
    end else if (state_r == S_WALK) begin
      tag_raddr = u_n[IDX_W-1:0];
    end
  end

  // Tag store: one write port, registered read.
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tdev_mem_r[cb] <= dev_r;
      tblk_mem_r[cb] <= blk_r;
    end
    tdev_q_r <= tdev_mem_r[tag_raddr];
    tblk_q_r <= tblk_mem_r[tag_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        ref_r[i] <= '0;
        vld_r[i] <= 1'b0;
        nxt_r[i] <= (i == 0) ? LINK_NIL : link_t'(i - 1);
        prv_r[i] <= (i == NUM_BUFFERS - 1) ? LINK_NIL : link_t'(i + 1);
        own_r[i] <= FREE_ID;
      end
      for (int l = 0; l < NUM_LISTS; l++) begin
        head_r[l] <= (l == int'(FREE_ID)) ? link_t'(NUM_BUFFERS - 1) : LINK_NIL;
        tail_r[l] <= (l == int'(FREE_ID)) ? link_t'(0) : LINK_NIL;
      end
    end else begin
      if (out_valid_r && out_if.ready && !fin_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            kind_r     <= in_if.kind;
            dev_r      <= in_if.device;
            blk_r      <= in_if.block;
            bin_r      <= in_if.buffer_in;
            rem_r      <= '0;
            lst_idle_r <= 1'b0;
            victim_r   <= 1'b0;
            res_bo_r   <= '0;
            res_st_r   <= ST_OK;
            res_hit_r  <= 1'b0;
            res_cnt_r  <= '0;
            grant_r    <= 1'b0;
            state_r    <= (in_if.kind == K_GET) ? S_MODH : S_OP;
          end
        end
        S_MODH: begin
          // Quotient by the bucket count from a reciprocal multiplication.
          prod_r  <= (2*BLK_W+1)'(blk_r) * (2*BLK_W+1)'(RECIP_M);
          state_r <= S_MODQ;
        end
        S_MODQ: begin
          rem_r   <= bkt_t'(blk_r - quo_x);
          state_r <= S_START;
        end
        S_START: begin
          cur_r   <= head_r[start_l];
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (cur_r[IDX_W]) begin
            if (!lst_idle_r) begin
              lst_idle_r <= 1'b1;
              state_r    <= S_START;
            end else begin
              state_r <= S_VIC;
            end
          end else if (tag_match) begin
            res_hit_r <= 1'b1;
            res_bo_r  <= cb;
            if (lst_idle_r) begin
              tgt_r   <= list_t'(rem_r);
              state_r <= S_UNL;
            end else if (ref_r[cb] == CNT_MAX) begin
              res_st_r  <= ST_CNTERR;
              res_cnt_r <= CNT_MAX;
              state_r   <= S_FIN;
            end else begin
              ref_r[cb] <= ref_r[cb] + cnt_t'(1);
              res_cnt_r <= ref_r[cb] + cnt_t'(1);
              grant_r   <= 1'b1;
              state_r   <= S_FIN;
            end
          end else begin
            cur_r <= u_n;
          end
        end
        S_VIC: begin
          tgt_r <= list_t'(rem_r);
          if (!vic_t[IDX_W]) begin
            cur_r    <= vic_t;
            victim_r <= 1'b1;
            state_r  <= S_UNL;
          end else if (!head_r[FREE_ID][IDX_W]) begin
            cur_r    <= head_r[FREE_ID];
            victim_r <= 1'b1;
            state_r  <= S_UNL;
          end else if (NUM_BUCKETS > 1) begin
            bkt_r   <= home_p1;
            k_r     <= bkt_t'(1);
            state_r <= S_SCAN;
          end else begin
            res_st_r <= ST_NOBUF;
            state_r  <= S_FIN;
          end
        end
        S_SCAN: begin
          if (!scan_t[IDX_W]) begin
            cur_r    <= scan_t;
            victim_r <= 1'b1;
            state_r  <= S_UNL;
          end else if (k_r == bkt_t'(NUM_BUCKETS - 1)) begin
            res_st_r <= ST_NOBUF;
            state_r  <= S_FIN;
          end else begin
            bkt_r <= bkt_p1;
            k_r   <= k_r + bkt_t'(1);
          end
        end
        S_UNL: begin
          if (u_p[IDX_W]) begin
            head_r[u_l] <= u_n;
          end else begin
            nxt_r[u_p[IDX_W-1:0]] <= u_n;
          end
          if (u_n[IDX_W]) begin
            tail_r[u_l] <= u_p;
          end else begin
            prv_r[u_n[IDX_W-1:0]] <= u_p;
          end
          if (kind_r == K_GET) begin
            ref_r[cb] <= cnt_t'(1);
            res_cnt_r <= cnt_t'(1);
            res_bo_r  <= cb;
            grant_r   <= 1'b1;
            if (victim_r) begin
              vld_r[cb] <= 1'b0;
            end
          end
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          prv_r[cb] <= LINK_NIL;
          nxt_r[cb] <= p_hd;
          if (p_hd[IDX_W]) begin
            tail_r[tgt_r] <= {1'b0, cb};
          end else begin
            prv_r[p_hd[IDX_W-1:0]] <= {1'b0, cb};
          end
          head_r[tgt_r] <= {1'b0, cb};
          own_r[cb]     <= tgt_r;
          state_r       <= S_FIN;
        end
        S_OP: begin
          res_bo_r <= bin_r;
          state_r  <= S_FIN;
          if ({1'b0, bin_r} >= (IDX_W+1)'(NUM_BUFFERS)) begin
            res_st_r <= ST_CNTERR;
          end else if (kind_r == K_PIN) begin
            if (hcnt == CNT_MAX) begin
              res_st_r  <= ST_CNTERR;
              res_cnt_r <= CNT_MAX;
            end else begin
              ref_r[bin_r] <= hcnt + cnt_t'(1);
              res_cnt_r    <= hcnt + cnt_t'(1);
            end
          end else if (hcnt == '0) begin
            res_st_r <= ST_CNTERR;
          end else begin
            ref_r[bin_r] <= hcnt - cnt_t'(1);
            res_cnt_r    <= hcnt - cnt_t'(1);
            if (kind_r == K_RELEASE && hcnt == cnt_t'(1)) begin
              // A tagged buffer sits on its bucket's in-use or idle list.
              cur_r   <= {1'b0, bin_r};
              tgt_r   <= (hown < list_t'(NUM_BUCKETS)) ?
                         hown + list_t'(NUM_BUCKETS) : hown;
              state_r <= S_UNL;
            end
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            out_valid_r <= 1'b1;
            out_bo_r    <= res_bo_r;
            out_st_r    <= res_st_r;
            out_hit_r   <= res_hit_r;
            out_cnt_r   <= res_cnt_r;
            out_rd_r    <= grant_r && !vld_r[cb];
            if (grant_r) begin
              vld_r[cb] <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.buffer_out  = out_bo_r;
  assign out_if.status      = out_st_r;
  assign out_if.tag_hit     = out_hit_r;
  assign out_if.need_read   = out_rd_r;
  assign out_if.count_after = out_cnt_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input accepted again while an item is in work");

  a_free_ends: assert property (@(posedge clk) disable iff (!rst_n)
    head_r[FREE_ID][IDX_W] == tail_r[FREE_ID][IDX_W])
    else $error("free list head and tail disagree on emptiness");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_fire && grant_r) |=> (out_if.status == ST_OK && out_if.count_after != '0))
    else $error("granted buffer reported with bad status or zero count");

  a_hit_not_nobuf: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_fire && res_hit_r) |=> (out_if.status != ST_NOBUF && !out_if.need_read))
    else $error("tag hit reported as no buffer or with a read request");

endmodule
